/* rtl/core/pfa_pkg.sv */
package pfa_pkg;

  // Sizing of the free stack and of addresses and byte counts.
  localparam int STACK_DEPTH = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int ADDR_BITS   = 52;
  localparam int SP_BITS     = $clog2(STACK_DEPTH);
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);

  // Field widths and stream bus widths.
  localparam int KIND_BITS     = 2;
  localparam int TYPE_BITS     = 3;
  localparam int STATUS_BITS   = 2;
  localparam int IN_DATA_BITS  = ((2 * ADDR_BITS + TYPE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((8 * ADDR_BITS + 7) / 8) * 8;

  // Item kinds.
  localparam logic [KIND_BITS-1:0] KIND_ADD_REGION = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_ALLOCATE   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_FREE       = 2'd2;

  // Region types.
  localparam logic [TYPE_BITS-1:0] RT_USABLE      = 3'd0;
  localparam logic [TYPE_BITS-1:0] RT_RESERVED    = 3'd1;
  localparam logic [TYPE_BITS-1:0] RT_BAD         = 3'd2;
  localparam logic [TYPE_BITS-1:0] RT_KERNEL      = 3'd3;
  localparam logic [TYPE_BITS-1:0] RT_FRAMEBUFFER = 3'd4;
  localparam logic [TYPE_BITS-1:0] RT_ACPI_RECL   = 3'd5;
  localparam logic [TYPE_BITS-1:0] RT_LOADER_RECL = 3'd6;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  // One free region on the stack.
  typedef struct packed {
    logic [ADDR_BITS-1:0] length;
    logic [ADDR_BITS-1:0] base;
  } region_t;

  // One result item.
  typedef struct packed {
    logic [ADDR_BITS-1:0]   reclaimable_bytes;
    logic [ADDR_BITS-1:0]   framebuffer_bytes;
    logic [ADDR_BITS-1:0]   kernel_bytes;
    logic [ADDR_BITS-1:0]   bad_bytes;
    logic [ADDR_BITS-1:0]   reserved_bytes;
    logic [ADDR_BITS-1:0]   usable_bytes;
    logic [ADDR_BITS-1:0]   overall_bytes;
    logic [ADDR_BITS-1:0]   alloc_base;
    logic [STATUS_BITS-1:0] status;
  } result_t;

endpackage

/* rtl/core/page_frame_free_list_allocator.sv */
// Page frame allocator built on a LIFO stack of free regions.
// The slave stream carries one item per transfer: s_tuser holds the kind
// (add region, allocate page, free page), s_tdata holds base, length and
// region type. Every accepted item gives exactly one result transfer on the
// master stream: m_tuser holds the status, m_tdata the allocated page base
// followed by the seven byte counters as they stand after the item.
// The result is valid in the cycle after the input transfer if the output
// is not stalled. Throughput is one item per cycle while s_tready is high,
// set by the single pass over the stack top and the counter adders; the top
// two stack entries live in registers and the rest in a one-write, one-read
// memory. A two-entry output buffer (output register plus skid register)
// lets the block take a new item while a result waits; if the receiver
// stalls for two results, s_tready drops until the skid register drains.
// Reset empties the stack and clears all counters and valid flags; it needs
// no clearing pass, since no unwritten stack entry is ever used.
module page_frame_free_list_allocator
  import pfa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // base, length, region_type
  input  logic [KIND_BITS-1:0]     s_tuser,   // kind
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // alloc_base, overall_bytes,
                                              // usable_bytes, reserved_bytes,
                                              // bad_bytes, kernel_bytes,
                                              // framebuffer_bytes,
                                              // reclaimable_bytes
  output logic [STATUS_BITS-1:0]   m_tuser    // status
);

  localparam logic [ADDR_BITS-1:0] PAGE_VAL = ADDR_BITS'(PAGE_BYTES);

  // Saturating add at the all-ones value.
  function automatic logic [ADDR_BITS-1:0] sat_add(input logic [ADDR_BITS-1:0] a,
                                                   input logic [ADDR_BITS-1:0] b);
    logic [ADDR_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_BITS] ? '1 : s[ADDR_BITS-1:0];
  endfunction

  // Stack storage: top two entries in registers, the rest in memory.
  region_t              stack_mem [STACK_DEPTH];
  region_t              top;
  region_t              below;
  logic [CNT_BITS-1:0]  stack_count;

  // Byte counters.
  logic [ADDR_BITS-1:0] overall_count, usable_count, reserved_count, bad_count;
  logic [ADDR_BITS-1:0] kernel_count, framebuffer_count, reclaim_count;
  logic [ADDR_BITS-1:0] overall_count_next, usable_count_next, reserved_count_next;
  logic [ADDR_BITS-1:0] bad_count_next, kernel_count_next, framebuffer_count_next;
  logic [ADDR_BITS-1:0] reclaim_count_next;

  // Output register and skid register.
  result_t result, out_reg, skid_reg;
  logic    skid_valid;

  // Input fields.
  logic [KIND_BITS-1:0] kind;
  logic [ADDR_BITS-1:0] in_base, in_length;
  logic [TYPE_BITS-1:0] region_type;
  logic                 accept;

  // Decoded operations.
  logic                 full, empty, do_push, do_pop, do_split;
  region_t              push_entry, split_entry;
  logic [CNT_BITS-1:0]  count_m1, count_m3;
  logic [SP_BITS-1:0]   wr_addr, rd_addr;
  logic [ADDR_BITS-1:0] type_sum, usable_sum, usable_diff;
  logic [ADDR_BITS-1:0] usable_addend;

  assign kind        = s_tuser;
  assign in_base     = s_tdata[ADDR_BITS-1:0];
  assign in_length   = s_tdata[2*ADDR_BITS-1:ADDR_BITS];
  assign region_type = s_tdata[2*ADDR_BITS+TYPE_BITS-1:2*ADDR_BITS];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // Stack addressing: memory holds entries below the top register.
  assign full     = (stack_count == CNT_BITS'(STACK_DEPTH));
  assign empty    = (stack_count == '0);
  assign count_m1 = stack_count - CNT_BITS'(1);
  assign count_m3 = stack_count - CNT_BITS'(3);
  assign wr_addr  = count_m1[SP_BITS-1:0];
  assign rd_addr  = count_m3[SP_BITS-1:0];

  // Operation decode for the accepted item.
  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_split   = 1'b0;
    push_entry = '{length: in_length, base: in_base};
    if (accept) begin
      case (kind)
        KIND_ADD_REGION: do_push = (region_type == RT_USABLE) && !full;
        KIND_ALLOCATE: begin
          do_split = !empty && (top.length > PAGE_VAL);
          do_pop   = !empty && !(top.length > PAGE_VAL);
        end
        KIND_FREE: begin
          do_push    = !full;
          push_entry = '{length: PAGE_VAL, base: in_base};
        end
        default: ;
      endcase
    end
  end

  assign split_entry = '{length: top.length - PAGE_VAL, base: top.base + PAGE_VAL};

  // Type counter sum and usable counter adder and subtractor.
  always_comb begin
    case (region_type)
      RT_RESERVED:    type_sum = reserved_count;
      RT_BAD:         type_sum = bad_count;
      RT_KERNEL:      type_sum = kernel_count;
      RT_FRAMEBUFFER: type_sum = framebuffer_count;
      default:        type_sum = reclaim_count;
    endcase
    type_sum      = sat_add(type_sum, in_length);
    usable_addend = (kind == KIND_FREE) ? PAGE_VAL : in_length;
    usable_sum    = sat_add(usable_count, usable_addend);
    usable_diff   = (usable_count > PAGE_VAL) ? usable_count - PAGE_VAL : '0;
  end

  // Counter updates and result assembly.
  always_comb begin
    overall_count_next     = overall_count;
    usable_count_next      = usable_count;
    reserved_count_next    = reserved_count;
    bad_count_next         = bad_count;
    kernel_count_next      = kernel_count;
    framebuffer_count_next = framebuffer_count;
    reclaim_count_next     = reclaim_count;
    result.status          = ST_OK;
    result.alloc_base      = '0;

    if (accept) begin
      case (kind)
        KIND_ADD_REGION: begin
          if (region_type == RT_USABLE && full) begin
            result.status = ST_FULL;
          end else begin
            overall_count_next = sat_add(overall_count, in_length);
            case (region_type) inside
              RT_USABLE:                    usable_count_next      = usable_sum;
              RT_RESERVED:                  reserved_count_next    = type_sum;
              RT_BAD:                       bad_count_next         = type_sum;
              RT_KERNEL:                    kernel_count_next      = type_sum;
              RT_FRAMEBUFFER:               framebuffer_count_next = type_sum;
              RT_ACPI_RECL, RT_LOADER_RECL: reclaim_count_next     = type_sum;
              default: ;
            endcase
          end
        end
        KIND_ALLOCATE: begin
          if (empty) begin
            result.status = ST_EMPTY;
          end else begin
            result.alloc_base = top.base;
            usable_count_next = usable_diff;
          end
        end
        KIND_FREE: begin
          if (full) begin
            result.status = ST_FULL;
          end else begin
            usable_count_next = usable_sum;
          end
        end
        default: ;
      endcase
    end

    result.overall_bytes     = overall_count_next;
    result.usable_bytes      = usable_count_next;
    result.reserved_bytes    = reserved_count_next;
    result.bad_bytes         = bad_count_next;
    result.kernel_bytes      = kernel_count_next;
    result.framebuffer_bytes = framebuffer_count_next;
    result.reclaimable_bytes = reclaim_count_next;
  end

  // Stack data path: a push spills the top into memory, a pop refills the
  // second entry with a registered memory read.
  always_ff @(posedge clk) begin
    if (do_push) begin
      if (!empty) begin
        stack_mem[wr_addr] <= top;
      end
      below <= top;
      top   <= push_entry;
    end else if (do_pop) begin
      top   <= below;
      below <= stack_mem[rd_addr];
    end else if (do_split) begin
      top <= split_entry;
    end
  end

  // Stack depth and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count       <= '0;
      overall_count     <= '0;
      usable_count      <= '0;
      reserved_count    <= '0;
      bad_count         <= '0;
      kernel_count      <= '0;
      framebuffer_count <= '0;
      reclaim_count     <= '0;
    end else begin
      if (do_push) begin
        stack_count <= stack_count + CNT_BITS'(1);
      end else if (do_pop) begin
        stack_count <= count_m1;
      end
      overall_count     <= overall_count_next;
      usable_count      <= usable_count_next;
      reserved_count    <= reserved_count_next;
      bad_count         <= bad_count_next;
      kernel_count      <= kernel_count_next;
      framebuffer_count <= framebuffer_count_next;
      reclaim_count     <= reclaim_count_next;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_reg <= skid_valid ? skid_reg : result;
    end else if (accept) begin
      skid_reg <= result;
    end
  end

  assign m_tuser = out_reg.status;
  assign m_tdata = OUT_DATA_BITS'(out_reg[$bits(result_t)-1:STATUS_BITS]);

endmodule
